// ===== rtl/utf8_to_utf16_transcoder_assert.svh =====
// assertion macros used by the checker
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// same-cycle implication
`define U8U16_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/u8u16_pkg.sv =====
package u8u16_pkg;

	localparam int FIFO_DEPTH = 4;

	localparam logic [7:0]  CONT_MASK   = 8'hC0;
	localparam logic [7:0]  CONT_MARK   = 8'h80;
	localparam logic [20:0] PAIR_OFFSET = 21'h10000;
	localparam logic [15:0] HIGH_BASE   = 16'hD800;
	localparam logic [15:0] LOW_BASE    = 16'hDC00;

	typedef struct packed {
		logic [15:0] unit;
		logic        last;
	} unit_t;

endpackage

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// utf-8 bytes in on the s_ side, utf-16 code units out on the m_ side. one byte is taken
// every cycle while the output buffer has room for two units; a byte passes the input
// register and is decoded from it once the buffer has that room, where the open-sequence
// state is updated and zero, one or two units enter a FIFO_DEPTH-entry output buffer, from
// which the first unit of a byte is offered. the output side moves one unit a cycle while
// m_tready is high, so a byte that closes a code point above 0xffff yields two units;
// the buffer absorbs those pairs and holds off s_tready only when it is
// nearly full. m_tlast marks the final unit that one byte produces. invalid leads and stray
// continuation bytes give nothing, a broken sequence is dropped and its breaking byte taken
// as a new lead, and s_tlast drops any sequence still open.
module utf8_to_utf16_transcoder #(
	parameter int FIFO_DEPTH = u8u16_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // byte_in[7:0]
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // code_unit[15:0]
	output logic        m_tlast    // last_of_run
);

	localparam int PTR_W = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;

	logic [20:0]       partial_q;
	logic [1:0]        needed_q;

	u8u16_pkg::unit_t  buf_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              go;
	logic              pop;
	logic [1:0]        push_n;
	logic [20:0]       partial_d;
	logic [1:0]        needed_d;
	logic              emit;
	logic [20:0]       point;
	logic [20:0]       asm_point;
	logic [20:0]       offs;
	logic [1:0]        needed_dec;
	u8u16_pkg::unit_t  unit0;
	u8u16_pkg::unit_t  unit1;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign go       = valid_s1 && (cnt_q <= CNT_W'(FIFO_DEPTH - 2));
	assign s_tready = !valid_s1 || go;
	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = buf_q[rd_ptr_q].unit;
	assign m_tlast  = buf_q[rd_ptr_q].last;
	assign pop      = m_tvalid && m_tready;

	always_comb begin
		asm_point  = {partial_q[14:0], byte_s1[5:0]};
		needed_dec = needed_q - 2'd1;
		partial_d  = '0;
		needed_d   = '0;
		emit       = 1'b0;
		point      = asm_point;
		if (needed_q != 2'd0 && (byte_s1 & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_MARK) begin
			needed_d = needed_dec;
			if (needed_dec == 2'd0) begin
				emit = 1'b1;
			end else begin
				partial_d = asm_point;
			end
		end else if (!byte_s1[7]) begin
			emit  = 1'b1;
			point = {13'd0, byte_s1};
		end else if (byte_s1[7:5] == 3'b110) begin
			partial_d = {16'd0, byte_s1[4:0]};
			needed_d  = 2'd1;
		end else if (byte_s1[7:4] == 4'b1110) begin
			partial_d = {17'd0, byte_s1[3:0]};
			needed_d  = 2'd2;
		end else if (byte_s1[7:3] == 5'b11110) begin
			partial_d = {18'd0, byte_s1[2:0]};
			needed_d  = 2'd3;
		end
		if (last_s1) begin
			partial_d = '0;
			needed_d  = '0;
		end

		offs = point - u8u16_pkg::PAIR_OFFSET;
		unit1.unit = u8u16_pkg::LOW_BASE + {6'd0, offs[9:0]};
		unit1.last = 1'b1;
		if (point[20:16] == 5'd0) begin
			unit0.unit = point[15:0];
			unit0.last = 1'b1;
			push_n     = emit ? 2'd1 : 2'd0;
		end else begin
			unit0.unit = u8u16_pkg::HIGH_BASE + {5'd0, offs[20:10]};
			unit0.last = 1'b0;
			push_n     = emit ? 2'd2 : 2'd0;
		end
		if (!go) begin
			push_n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			needed_q  <= '0;
		end else if (go) begin
			partial_q <= partial_d;
			needed_q  <= needed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			buf_q[wr_ptr_q] <= unit0;
		end
		if (push_n == 2'd2) begin
			buf_q[ptr_inc(wr_ptr_q)] <= unit1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end else if (push_n == 2'd2) begin
				wr_ptr_q <= ptr_inc(ptr_inc(wr_ptr_q));
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			cnt_q <= cnt_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/u8u16_checker.sv =====
`include "utf8_to_utf16_transcoder_assert.svh"

module u8u16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// held unit stays put
	`U8U16_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// a unit that is not the last of its byte is a surrogate half
	`U8U16_ASSERT_IMPL(a_high_half, clk, arst_n, m_tvalid && !m_tlast, m_tdata[15:11] == 5'b11011)

	// a high half is followed at once by its low half
	`U8U16_ASSERT_NEXT(a_low_follows, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast && m_tdata[15:10] == 6'b110111)

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_u8u16_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== dv/utf16_unit_checker.sv =====
module utf16_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // byte_in[7:0]
	input  logic        s_tlast,   // end_of_text
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // code_unit[15:0]
	input  logic        m_tlast,   // last_of_run
	output int          mismatches,
	output int          units_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [20:0]       point_acc = '0;
	logic [1:0]        cont_left = '0;
	u8u16_pkg::unit_t  pending_units[$];
	u8u16_pkg::unit_t  exp_unit;
	int                err_cnt = 0;

	function automatic void emit_point(input logic [20:0] cp);
		logic [20:0]      off;
		u8u16_pkg::unit_t u;
		if (cp <= 21'h00FFFF) begin
			u.unit = cp[15:0];
			u.last = 1'b1;
			pending_units.insert(pending_units.size(), u);
		end else begin
			off = cp - u8u16_pkg::PAIR_OFFSET;
			u.unit = u8u16_pkg::HIGH_BASE + {5'd0, off[20:10]};
			u.last = 1'b0;
			pending_units.insert(pending_units.size(), u);
			u.unit = u8u16_pkg::LOW_BASE + {6'd0, off[9:0]};
			u.last = 1'b1;
			pending_units.insert(pending_units.size(), u);
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic eot);
		if (cont_left != 2'd0 && (b & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_MARK) begin
			point_acc = {point_acc[14:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0) begin
				emit_point(point_acc);
				point_acc = '0;
			end
		end else begin
			// open sequence, if any, is dropped and this byte taken as a lead
			cont_left = '0;
			point_acc = '0;
			if (!b[7]) begin
				emit_point({13'd0, b});
			end else if (b[7:5] == 3'b110) begin
				point_acc = {16'd0, b[4:0]};
				cont_left = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				point_acc = {17'd0, b[3:0]};
				cont_left = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				point_acc = {18'd0, b[2:0]};
				cont_left = 2'd3;
			end
		end
		if (eot) begin
			cont_left = '0;
			point_acc = '0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_acc = '0;
			cont_left = '0;
			pending_units.delete();
			err_cnt = 0;
			mismatches <= 0;
			units_pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_units.size() == 0) begin
					$display("%0t: unit %h (last %b) with nothing expected",
						$time, m_tdata, m_tlast);
					err_cnt++;
				end else begin
					exp_unit = pending_units.pop_front();
					if (m_tdata !== exp_unit.unit) begin
						$display("%0t: code unit expected %h actual %h",
							$time, exp_unit.unit, m_tdata);
						err_cnt++;
					end
					if (m_tlast !== exp_unit.last) begin
						$display("%0t: last flag expected %b actual %b",
							$time, exp_unit.last, m_tlast);
						err_cnt++;
					end
				end
			end
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
			mismatches <= err_cnt;
			units_pending <= pending_units.size();
		end
	end

endmodule

// ===== dv/tb_utf8_to_utf16_transcoder.sv =====
module tb_utf8_to_utf16_transcoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TEXT_BYTES  = 1750;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_EVERY_THIRD,
		READY_SPARSE
	} ready_mode_e;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	int          mismatches;
	int          units_pending;
	int          cycles     = 0;
	int          burst_left = 0;
	int          mode_left  = 0;
	ready_mode_e ready_mode = READY_ALWAYS;

	always #2 clk = ~clk;

	utf8_to_utf16_transcoder i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	utf16_unit_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.mismatches   (mismatches),
		.units_pending(units_pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver stalls in stretches of changing character
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode <= ready_mode_e'($urandom_range(0, 3));
			mode_left <= $urandom_range(20, 300);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (ready_mode)
			READY_ALWAYS:      m_tready <= 1'b1;
			READY_COIN:        m_tready <= ($urandom_range(0, 1) == 1);
			READY_EVERY_THIRD: m_tready <= (cycles % 3 == 0);
			default:           m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	task automatic send_byte(input logic [7:0] b, input logic eot);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eot;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 250)
				: $urandom_range(0, 30);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (units_pending != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		logic [7:0] directed_bytes[$];
		logic [7:0] text_q[$];
		logic [7:0] rnd;
		int         sent;
		int         kind;
		int         n_bytes;
		int         keep;
		logic       flag_end;

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ascii extremes, largest two-byte point, three-byte extremes, smallest and largest four-byte points,
		// invalid leads, stray continuation, broken sequence
		directed_bytes = '{8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
			8'hE0, 8'h80, 8'h80, 8'hF0, 8'h90, 8'h80, 8'h80,
			8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hF8, 8'hFF, 8'h80, 8'hC3, 8'h41};
		foreach (directed_bytes[i])
			send_byte(directed_bytes[i], 1'b0);
		// text ending inside an open sequence
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b1);
		wait_drained();

		sent = 0;
		while (sent < TEXT_BYTES) begin
			text_q.delete();
			repeat ($urandom_range(1, 16)) begin
				kind = $urandom_range(0, 9);
				rnd = $urandom;
				if (kind == 9) begin
					// noise byte
					text_q.insert(text_q.size(), rnd);
					sent += 1;
				end else begin
					n_bytes = (kind < 3) ? 1 : (kind < 5) ? 2 : (kind < 7) ? 3 : 4;
					keep = n_bytes;
					if (n_bytes > 1 && $urandom_range(0, 7) == 0)
						keep = $urandom_range(1, n_bytes - 1);
					case (n_bytes)
						1:       text_q.insert(text_q.size(), {1'b0, rnd[6:0]});
						2:       text_q.insert(text_q.size(), {3'b110, rnd[4:0]});
						3:       text_q.insert(text_q.size(), {4'b1110, rnd[3:0]});
						default: text_q.insert(text_q.size(), {5'b11110, rnd[2:0]});
					endcase
					repeat (keep - 1) begin
						rnd = $urandom;
						text_q.insert(text_q.size(), {2'b10, rnd[5:0]});
					end
					sent += keep;
				end
			end
			flag_end = ($urandom_range(0, 7) != 0);
			foreach (text_q[i])
				send_byte(text_q[i], flag_end && (i == text_q.size() - 1));
			if ($urandom_range(0, 29) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (8)
			@(posedge clk);
		if (mismatches == 0 && units_pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/u8u16_pkg.sv
rtl/utf8_to_utf16_transcoder.sv
rtl/u8u16_checker.sv
dv/utf16_unit_checker.sv
dv/tb_utf8_to_utf16_transcoder.sv
